### rtl/core/column_major_offset_checker_assert.svh
// assertion macros for the column-major offset checker
// no dependencies; the assertion files pull this in with an include
`ifndef COLUMN_MAJOR_OFFSET_CHECKER_ASSERT_SVH
`define COLUMN_MAJOR_OFFSET_CHECKER_ASSERT_SVH

// assertion on an explicit clock and active-low reset
`define CMOC_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("column_major_offset_checker assertion failed");

// assertion on the block clock and reset
`define CMOC_ASSERT(lbl, prop) \
  `CMOC_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

### rtl/core/cmoc_pkg.sv
// shared constants, request/response types and pipeline stage type
// of the column-major offset checker; no dependencies
`default_nettype none

package cmoc_pkg;

  localparam int MAX_DIMS   = 10;
  localparam int INDEX_BITS = 16;

  localparam int FIELD_W    = 16;
  localparam int OFF_W      = 31;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int DIM_CNT_W  = 4;
  localparam int BOUND_REGS = 5;
  localparam int DIFF_W     = INDEX_BITS;
  localparam int EXT_W      = INDEX_BITS + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS_BASE = 3'd1;

  typedef struct packed {
    logic signed [FIELD_W-1:0] subscript_0;
    logic signed [FIELD_W-1:0] subscript_1;
    logic signed [FIELD_W-1:0] subscript_2;
    logic signed [FIELD_W-1:0] subscript_3;
    logic signed [FIELD_W-1:0] subscript_4;
    logic signed [FIELD_W-1:0] subscript_5;
    logic signed [FIELD_W-1:0] subscript_6;
    logic signed [FIELD_W-1:0] subscript_7;
    logic signed [FIELD_W-1:0] subscript_8;
    logic signed [FIELD_W-1:0] subscript_9;
  } in_req_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic             error;
  } out_rsp_t;

  typedef struct packed {
    logic [MAX_DIMS-1:0][INDEX_BITS-1:0] subs;
    logic [OFF_W-1:0]                    mult;
    logic                                big;
    logic [OFF_W-1:0]                    loc;
    logic                                err;
  } stage_t;

  function automatic logic [INDEX_BITS-1:0] sub_of(input in_req_t r, input int k);
    logic [INDEX_BITS-1:0] s;
    unique case (k)
      0:       s = r.subscript_0[INDEX_BITS-1:0];
      1:       s = r.subscript_1[INDEX_BITS-1:0];
      2:       s = r.subscript_2[INDEX_BITS-1:0];
      3:       s = r.subscript_3[INDEX_BITS-1:0];
      4:       s = r.subscript_4[INDEX_BITS-1:0];
      5:       s = r.subscript_5[INDEX_BITS-1:0];
      6:       s = r.subscript_6[INDEX_BITS-1:0];
      7:       s = r.subscript_7[INDEX_BITS-1:0];
      8:       s = r.subscript_8[INDEX_BITS-1:0];
      9:       s = r.subscript_9[INDEX_BITS-1:0];
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/core/cmoc_stage.sv
// one dimension step of the offset pipeline: bounds check, offset
// accumulate and stride update, followed by the stage register; uses cmoc_pkg
`default_nettype none

module cmoc_stage import cmoc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic                  active_i,
  input  stage_t                st_i,
  input  logic [INDEX_BITS-1:0] sub_i,
  input  logic [INDEX_BITS-1:0] lo_i,
  input  logic [INDEX_BITS-1:0] hi_i,
  output logic                  valid_o,
  output stage_t                st_o
);

  localparam int PROD_W = DIFF_W + OFF_W;
  localparam int MULT_W = EXT_W + OFF_W;

  logic signed [INDEX_BITS:0] sx, lx, hx, dsub, dhl;
  logic [DIFF_W-1:0]          diff;
  logic [EXT_W-1:0]           ext;
  logic [PROD_W-1:0]          prod;
  logic [PROD_W:0]            sum;
  logic [MULT_W-1:0]          mprod;
  logic                       bad_ord, out_rng, ovf, step_err;
  logic                       valid_q;
  stage_t                     st_d, st_q;

  assign sx   = {sub_i[INDEX_BITS-1], sub_i};
  assign lx   = {lo_i[INDEX_BITS-1], lo_i};
  assign hx   = {hi_i[INDEX_BITS-1], hi_i};
  assign dsub = sx - lx;
  assign dhl  = hx - lx;
  assign diff = dsub[DIFF_W-1:0];
  assign ext  = {1'b0, dhl[INDEX_BITS-1:0]} + EXT_W'(1);

  assign bad_ord = lx > hx;
  assign out_rng = (sx < lx) || (sx > hx);

  assign prod  = {{OFF_W{1'b0}}, diff} * {{DIFF_W{1'b0}}, st_i.mult};
  assign sum   = {1'b0, prod} + {{(PROD_W + 1 - OFF_W){1'b0}}, st_i.loc};
  assign ovf   = (|sum[PROD_W:OFF_W]) || (st_i.big && (|diff));
  assign mprod = {{OFF_W{1'b0}}, ext} * {{EXT_W{1'b0}}, st_i.mult};

  assign step_err = bad_ord || out_rng || ovf;

  always_comb begin
    st_d = st_i;
    if (active_i && !st_i.err) begin
      st_d.loc  = sum[OFF_W-1:0];
      st_d.mult = mprod[OFF_W-1:0];
      st_d.big  = st_i.big || (|mprod[MULT_W-1:OFF_W]);
      st_d.err  = step_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

`default_nettype wire

### rtl/core/column_major_offset_checker.sv
// top level of the column-major offset checker: config registers, input
// register and one pipeline stage per dimension; uses cmoc_pkg and cmoc_stage
//
//   channel  direction  handshake                 payload
//   cfg      in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//   in       in         in_valid_i / in_ready_o   in_req_i (in_req_t)
//   out      out        out_valid_o / out_ready_i out_rsp_o (out_rsp_t)
//
// one request accepted per cycle while in_ready_o is high, one response each, in order
// path: input register plus one stage per dimension
// each stage holds one bounds check, one offset multiply-add and one stride multiply
// stalls back up stage by stage; bubbles are squeezed out while the output waits
// reset clears valid bits, sets dim_count to 1 and all bounds to 0
`default_nettype none

module column_major_offset_checker import cmoc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_req_t              in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_rsp_t             out_rsp_o
);

  logic [DIM_CNT_W-1:0] dim_count_q;
  logic [CFG_W-1:0]     bounds_q [BOUND_REGS];

  logic [MAX_DIMS:0]    en;
  logic [MAX_DIMS:0]    v;
  stage_t               st [MAX_DIMS+1];
  logic                 v0_q;
  stage_t               st0_d, st0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q <= DIM_CNT_W'(1);
      for (int r = 0; r < BOUND_REGS; r++) begin
        bounds_q[r] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_DIM_COUNT) begin
        dim_count_q <= cfg_wdata_i[DIM_CNT_W-1:0];
      end
      for (int r = 0; r < BOUND_REGS; r++) begin
        if (cfg_idx_i == CFG_BOUNDS_BASE + CFG_IDX_W'(r)) begin
          bounds_q[r] <= cfg_wdata_i;
        end
      end
    end
  end

  // backpressure chain
  always_comb begin
    en[MAX_DIMS] = !v[MAX_DIMS] || out_ready_i;
    for (int i = MAX_DIMS - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready_o = en[0];

  always_comb begin
    st0_d      = '0;
    st0_d.mult = OFF_W'(1);
    st0_d.err  = (dim_count_q == '0) || (dim_count_q > DIM_CNT_W'(MAX_DIMS));
    for (int k = 0; k < MAX_DIMS; k++) begin
      st0_d.subs[k] = sub_of(in_req_i, k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en[0]) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      st0_q <= st0_d;
    end
  end

  assign v[0]  = v0_q;
  assign st[0] = st0_q;

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim
    localparam int Reg   = k / 2;
    localparam int LoPos = FIELD_W * (2 * (k % 2));
    localparam int HiPos = FIELD_W * (2 * (k % 2) + 1);

    cmoc_stage u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en[k+1]),
      .valid_i  (v[k]),
      .active_i (DIM_CNT_W'(k) < dim_count_q),
      .st_i     (st[k]),
      .sub_i    (st[k].subs[k]),
      .lo_i     (bounds_q[Reg][LoPos +: INDEX_BITS]),
      .hi_i     (bounds_q[Reg][HiPos +: INDEX_BITS]),
      .valid_o  (v[k+1]),
      .st_o     (st[k+1])
    );
  end

  assign out_valid_o      = v[MAX_DIMS];
  assign out_rsp_o.offset = st[MAX_DIMS].err ? '0 : st[MAX_DIMS].loc;
  assign out_rsp_o.error  = st[MAX_DIMS].err;

endmodule

`default_nettype wire

### rtl/core/cmoc_checker.sv
// port-level assertions for the column-major offset checker and the bind
// that attaches them; uses cmoc_pkg and column_major_offset_checker_assert.svh
`default_nettype none

`include "column_major_offset_checker_assert.svh"

module cmoc_checker import cmoc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input in_req_t              in_req_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input out_rsp_t             out_rsp_o
);

  // a flagged response never carries an offset
  `CMOC_ASSERT(a_err_zero, out_valid_o && out_rsp_o.error |-> out_rsp_o.offset == '0)

  // input only stalls when every stage is full and the output is blocked
  `CMOC_ASSERT(a_backpressure, !in_ready_o |-> out_valid_o && !out_ready_i)

  // stalled request holds
  `CMOC_ASSERT(a_in_hold, in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_req_i))

  // stalled response holds
  `CMOC_ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))

endmodule

bind column_major_offset_checker cmoc_checker u_cmoc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire
